// File: rtl/core/ryuv_pkg.sv
// Shared types, constants and coefficient table for the RGB to YUV 4:2:0 converter.
// Used by every module under rtl/core; depends on nothing else.
`default_nettype none

package ryuv_pkg;

  // Configuration register layout.
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 13'd1920;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 13'd1080;
  localparam logic [CFG_W-1:0] FRAME_DIM_MIN      = 13'd2;

  // Defaults for the top-level parameters.
  localparam int MAX_WIDTH_DEFAULT   = 4096;
  localparam int MAX_HEIGHT_DEFAULT  = 4096;
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  localparam int PIX_W    = 8;
  localparam int PLANE_W  = 2;
  localparam int COEF_W   = 9;
  localparam int OFFS_W   = 11;

  typedef enum logic [PLANE_W-1:0] {
    PLANE_Y = 2'd0,
    PLANE_U = 2'd1,
    PLANE_V = 2'd2
  } plane_t;

  // One pixel as it travels from the front end to the back end.
  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             chroma;      // pixel also yields U and V
    logic             frame_last;  // last pixel of the frame
  } pix_item_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] c_r;
    logic signed [COEF_W-1:0] c_g;
    logic signed [COEF_W-1:0] c_b;
    logic signed [OFFS_W-1:0] offs;
  } coef_t;

  // BT.601 studio-range matrix, one row per plane.
  function automatic coef_t plane_coef(plane_t p);
    coef_t c;
    unique case (p)
      PLANE_Y: c = '{c_r: 9'sd66,  c_g: 9'sd129, c_b: 9'sd25,  offs: 11'sd16};
      PLANE_U: c = '{c_r: -9'sd38, c_g: -9'sd74, c_b: 9'sd112, offs: 11'sd128};
      PLANE_V: c = '{c_r: 9'sd112, c_g: -9'sd94, c_b: -9'sd18, offs: 11'sd128};
      default: c = '{c_r: 9'sd0,   c_g: 9'sd0,   c_b: 9'sd0,   offs: 11'sd0};
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/rgb_to_yuv420_convert.sv
// Throughput: one result per cycle while a pixel waits and the output register is
// empty or popped; a pixel at an even row and column yields three results, every
// other pixel one. The single shared result datapath in the back end sets that rate.
// Reset (rst, synchronous, active high) empties the pixel queue and the output
// register, zeroes the counters and sets the frame size to 1920 by 1080.
`default_nettype none

module rgb_to_yuv420_convert #(
  parameter int MAX_WIDTH   = ryuv_pkg::MAX_WIDTH_DEFAULT,
  parameter int MAX_HEIGHT  = ryuv_pkg::MAX_HEIGHT_DEFAULT,
  parameter int QUEUE_DEPTH = ryuv_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  // Configuration write port: register 0 is the frame width, 1 the height.
  input  logic                           cfg_write,
  input  logic [ryuv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ryuv_pkg::CFG_W-1:0]     cfg_data,
  // Pixel input, a queue write side.
  input  logic                           push,
  output logic                           full,
  input  logic [ryuv_pkg::PIX_W-1:0]     red,
  input  logic [ryuv_pkg::PIX_W-1:0]     green,
  input  logic [ryuv_pkg::PIX_W-1:0]     blue,
  // Result output, a queue read side.
  output logic                           empty,
  input  logic                           pop,
  output logic [ryuv_pkg::PLANE_W-1:0]   plane,
  output logic [ryuv_pkg::PIX_W-1:0]     sample,
  output logic                           last_of_pixel,
  output logic                           frame_end
);
  import ryuv_pkg::*;

  // The front end tags each pixel with its chroma and frame-end flags as it
  // is accepted, so the position counters run at the input rate. The queue
  // lets the front keep taking pixels while the back end is busy emitting
  // the three results of a chroma pixel or is held by a full output stage.
  logic      q_write;
  pix_item_t q_item;
  logic      q_full;
  logic      q_head_valid;
  pix_item_t q_head;
  logic      q_pop;

  assign full = q_full;

  ryuv_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .q_full    (q_full),
    .q_write   (q_write),
    .q_item    (q_item)
  );

  ryuv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .wr         (q_write),
    .wr_item    (q_item),
    .rd         (q_pop),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  // The back end holds a pixel at the queue head until its last result has
  // gone into the output register; that register is reloaded in the same
  // cycle it is popped, so results stream without bubbles.
  ryuv_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (q_head_valid),
    .head          (q_head),
    .head_pop      (q_pop),
    .pop           (pop),
    .empty         (empty),
    .plane         (plane),
    .sample        (sample),
    .last_of_pixel (last_of_pixel),
    .frame_end     (frame_end)
  );

endmodule

`default_nettype wire

// File: rtl/core/ryuv_front.sv
// Front end: configuration registers, column/row tracking and pixel classification.
// Depends on ryuv_pkg.
`default_nettype none

module ryuv_front #(
  parameter int MAX_WIDTH  = ryuv_pkg::MAX_WIDTH_DEFAULT,
  parameter int MAX_HEIGHT = ryuv_pkg::MAX_HEIGHT_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [ryuv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ryuv_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                push,
  input  logic [ryuv_pkg::PIX_W-1:0]          red,
  input  logic [ryuv_pkg::PIX_W-1:0]          green,
  input  logic [ryuv_pkg::PIX_W-1:0]          blue,
  input  logic                                q_full,
  output logic                                q_write,
  output ryuv_pkg::pix_item_t                 q_item
);
  import ryuv_pkg::*;

  localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WD_W  = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
  localparam int HD_W  = (ROW_W + 1 > CFG_W) ? ROW_W + 1 : CFG_W;
  localparam logic [WD_W-1:0] WIDTH_LIMIT  = WD_W'(MAX_WIDTH);
  localparam logic [HD_W-1:0] HEIGHT_LIMIT = HD_W'(MAX_HEIGHT);

  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;

  logic [WD_W-1:0]  width_eff;
  logic [HD_W-1:0]  height_eff;
  logic             accept;
  logic             row_end;
  logic             frame_last;

  // Effective frame size: at least two, at most the built-in limit.
  always_comb begin
    if (frame_width < FRAME_DIM_MIN) begin
      width_eff = WD_W'(FRAME_DIM_MIN);
    end else if (WD_W'(frame_width) > WIDTH_LIMIT) begin
      width_eff = WIDTH_LIMIT;
    end else begin
      width_eff = WD_W'(frame_width);
    end
    if (frame_height < FRAME_DIM_MIN) begin
      height_eff = HD_W'(FRAME_DIM_MIN);
    end else if (HD_W'(frame_height) > HEIGHT_LIMIT) begin
      height_eff = HEIGHT_LIMIT;
    end else begin
      height_eff = HD_W'(frame_height);
    end
  end

  // A counter at or past the last position wraps, which also covers a size
  // that shrank in the middle of a frame.
  assign accept     = push && !q_full;
  assign row_end    = (WD_W'(column_count) + WD_W'(1)) >= width_eff;
  assign frame_last = row_end && ((HD_W'(row_count) + HD_W'(1)) >= height_eff);

  assign q_write             = accept;
  assign q_item.red          = red;
  assign q_item.green        = green;
  assign q_item.blue         = blue;
  assign q_item.chroma       = !row_count[0] && !column_count[0];
  assign q_item.frame_last   = frame_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (row_end) begin
        column_count <= '0;
        if (frame_last) begin
          row_count <= '0;
        end else begin
          row_count <= ROW_W'(row_count + 1'b1);
        end
      end else begin
        column_count <= COL_W'(column_count + 1'b1);
      end
    end
  end

  a_col_step: assert property (@(posedge clk) disable iff (rst)
    accept && !row_end |=> column_count == COL_W'($past(column_count) + 1'b1))
    else $error("column counter did not advance");
  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && frame_last |=> column_count == '0 && row_count == '0)
    else $error("counters did not wrap at frame end");
  a_last_on_row_end: assert property (@(posedge clk) disable iff (rst)
    q_item.frame_last |-> row_end)
    else $error("frame end flagged away from a row end");

endmodule

`default_nettype wire

// File: rtl/core/ryuv_queue.sv
// Short first-in first-out queue of classified pixels between front and back end.
// Depends on ryuv_pkg.
`default_nettype none

module ryuv_queue #(
  parameter int DEPTH = ryuv_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr,
  input  ryuv_pkg::pix_item_t  wr_item,
  input  logic                 rd,
  output logic                 full,
  output logic                 head_valid,
  output ryuv_pkg::pix_item_t  head
);
  import ryuv_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pix_item_t        slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = count == CNT_W'(DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr + 1'b1);
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr + 1'b1);
      end
      if (wr && !rd) begin
        count <= CNT_W'(count + 1'b1);
      end else if (rd && !wr) begin
        count <= CNT_W'(count - 1'b1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue holds more items than its depth");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd |-> head_valid)
    else $error("queue read while empty");
  a_no_write_full: assert property (@(posedge clk) disable iff (rst)
    wr |-> !full || rd)
    else $error("queue written while full");

endmodule

`default_nettype wire

// File: rtl/core/ryuv_back.sv
// Back end: expands each pixel into one luma and optionally two chroma results, one
// per cycle into a registered output stage that is empty or popped. Depends on ryuv_pkg.
`default_nettype none

module ryuv_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         head_valid,
  input  ryuv_pkg::pix_item_t          head,
  output logic                         head_pop,
  input  logic                         pop,
  output logic                         empty,
  output logic [ryuv_pkg::PLANE_W-1:0] plane,
  output logic [ryuv_pkg::PIX_W-1:0]   sample,
  output logic                         last_of_pixel,
  output logic                         frame_end
);
  import ryuv_pkg::*;

  localparam int PROD_W = 2 * COEF_W;
  localparam int ACC_W  = PROD_W + 1;

  typedef enum logic [1:0] {PH_Y, PH_U, PH_V} phase_t;

  phase_t                   phase;
  phase_t                   phase_next;
  logic                     out_valid;
  logic                     step;
  logic                     last_res;
  plane_t                   cur_plane;
  coef_t                    coef;
  logic signed [PROD_W-1:0] p_r;
  logic signed [PROD_W-1:0] p_g;
  logic signed [PROD_W-1:0] p_b;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_sh;
  logic signed [OFFS_W-1:0] biased;
  logic [PIX_W-1:0]         clamped;

  always_comb begin
    unique case (phase)
      PH_Y:    cur_plane = PLANE_Y;
      PH_U:    cur_plane = PLANE_U;
      PH_V:    cur_plane = PLANE_V;
      default: cur_plane = PLANE_Y;
    endcase
  end

  // Three small constant products, a rounding sum and a floor shift by 256.
  always_comb begin
    coef   = plane_coef(cur_plane);
    p_r    = coef.c_r * $signed({1'b0, head.red});
    p_g    = coef.c_g * $signed({1'b0, head.green});
    p_b    = coef.c_b * $signed({1'b0, head.blue});
    acc    = ACC_W'(p_r) + ACC_W'(p_g) + ACC_W'(p_b) + ACC_W'(128);
    acc_sh = acc >>> 8;
    biased = OFFS_W'(acc_sh) + coef.offs;
    if (biased < 0) begin
      clamped = '0;
    end else if (biased > OFFS_W'(255)) begin
      clamped = '1;
    end else begin
      clamped = PIX_W'(biased);
    end
  end

  assign step     = head_valid && (!out_valid || pop);
  assign last_res = (phase == PH_V) || (phase == PH_Y && !head.chroma);
  assign head_pop = step && last_res;
  assign empty    = !out_valid;

  always_comb begin
    unique case (phase)
      PH_Y:    phase_next = head.chroma ? PH_U : PH_Y;
      PH_U:    phase_next = PH_V;
      PH_V:    phase_next = PH_Y;
      default: phase_next = PH_Y;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_Y;
      out_valid <= 1'b0;
    end else begin
      if (step) begin
        phase         <= phase_next;
        out_valid     <= 1'b1;
        plane         <= cur_plane;
        sample        <= clamped;
        last_of_pixel <= last_res;
        frame_end     <= last_res && head.frame_last;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_head_held: assert property (@(posedge clk) disable iff (rst)
    phase != PH_Y |-> head_valid)
    else $error("pixel left the queue before its chroma results");
  a_u_then_v: assert property (@(posedge clk) disable iff (rst)
    step && phase == PH_U |=> phase == PH_V)
    else $error("U result not followed by V result");
  a_frame_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> last_of_pixel)
    else $error("frame end on a result that is not a pixel's last");

endmodule

`default_nettype wire
